// File: rtl/ram_pkg.sv
package ram_pkg;

  // Element type codes held in the configuration register.
  typedef enum logic [3:0] {
    ET_U8   = 4'd0,
    ET_I8   = 4'd1,
    ET_I16  = 4'd2,
    ET_I32  = 4'd3,
    ET_I64  = 4'd4,
    ET_U16  = 4'd5,
    ET_U32  = 4'd6,
    ET_U64  = 4'd7,
    ET_F32  = 4'd8,
    ET_F64  = 4'd9,
    ET_F16  = 4'd10,
    ET_BF16 = 4'd11
  } elem_type_t;

  localparam longint unsigned MAX_ROW_LENGTH_DEF = 64'd65536;

  typedef struct packed {
    logic [63:0] element_bits;
    logic        last_in_row;
  } in_req_t;

  typedef struct packed {
    logic [15:0] min_index;
    logic        row_overflow;
  } out_req_t;

  // Integer strict less-than, width w, optional sign.
  function automatic logic int_less(input logic [63:0] a, input logic [63:0] b,
                                    input int unsigned w, input logic sgn);
    logic [63:0] m;
    logic [63:0] aa;
    logic [63:0] bb;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    aa = a & m;
    bb = b & m;
    if (sgn) begin
      aa = aa ^ (64'd1 << (w - 1));
      bb = bb ^ (64'd1 << (w - 1));
    end
    return aa < bb;
  endfunction

  // Float strict less-than: w bits total, f fraction bits. NaN never wins,
  // and the two zeros compare equal.
  function automatic logic float_less(input logic [63:0] a, input logic [63:0] b,
                                      input int unsigned w, input int unsigned f);
    logic [63:0] sgn;
    logic [63:0] mag;
    logic [63:0] frc;
    logic [63:0] ex;
    logic [63:0] am;
    logic [63:0] bm;
    logic an;
    logic bn;
    logic res;
    sgn = 64'd1 << (w - 1);
    mag = sgn - 64'd1;
    frc = (64'd1 << f) - 64'd1;
    ex  = mag & ~frc;
    am  = a & mag;
    bm  = b & mag;
    an  = (a & sgn) != 64'd0;
    bn  = (b & sgn) != 64'd0;
    if (((am & ex) == ex && (am & frc) != 64'd0) ||
        ((bm & ex) == ex && (bm & frc) != 64'd0)) begin
      res = 1'b0;
    end else if (am == 64'd0 && bm == 64'd0) begin
      res = 1'b0;
    end else if (an != bn) begin
      res = an;
    end else if (!an) begin
      res = am < bm;
    end else begin
      res = am > bm;
    end
    return res;
  endfunction

endpackage

// File: rtl/row_argmin_reduction.sv
// Row argmin reduction.
// Input channel in_valid/in_ready/in_data carries one row element per request,
// with last_in_row set on the row's final element. The output channel
// out_valid/out_ready/out_data delivers one request per row: the index of the
// first smallest element and an overflow flag for rows longer than
// MAX_ROW_LENGTH. The cfg channel writes the element type; write it only while
// the block is idle.
// Each element is compared against the running minimum as it is accepted, so
// one element is accepted every cycle while in_ready is high. The result is
// in the output register in the cycle after the last element is accepted.
// When the receiver stalls, the result is held in the output register and
// in_ready drops at once, so no element is taken until the held result is
// taken; a result accepted in the same cycle frees the input for that cycle.
// Reset (rst_n low, synchronous) clears the running state, selects u8 and
// empties the output register.
module row_argmin_reduction #(
  parameter longint unsigned MAX_ROW_LENGTH = ram_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ram_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ram_pkg::out_req_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);

  localparam int CW = $clog2(MAX_ROW_LENGTH + 1);

  logic [3:0]    etype_r;
  logic [63:0]   best_r;
  logic [CW-1:0] bpos_r;
  logic [CW-1:0] cpos_r;
  logic          start_r;
  logic          ovf_r;
  logic          less;
  logic          acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign acc       = in_valid && in_ready;

  ram_cmp u_cmp (
    .elem_type(etype_r),
    .a        (in_data.element_bits),
    .b        (best_r),
    .less     (less)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r <= ram_pkg::ET_U8;
    end else if (cfg_valid) begin
      etype_r <= cfg_data;
    end
  end

  // Running minimum and position tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= '0;
      bpos_r  <= '0;
      cpos_r  <= '0;
      start_r <= 1'b1;
      ovf_r   <= 1'b0;
    end else if (acc) begin
      if (start_r) begin
        best_r <= in_data.element_bits;
        bpos_r <= '0;
        cpos_r <= CW'(1);
        ovf_r  <= 1'b0;
      end else if (64'(cpos_r) >= MAX_ROW_LENGTH) begin
        ovf_r  <= 1'b1;
      end else begin
        if (less) begin
          best_r <= in_data.element_bits;
          bpos_r <= cpos_r;
        end
        cpos_r <= cpos_r + CW'(1);
      end
      start_r <= in_data.last_in_row;
    end
  end

  // Result register: formed from the same-cycle update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (acc && in_data.last_in_row) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.last_in_row) begin
      if (start_r) begin
        out_data.min_index    <= '0;
        out_data.row_overflow <= 1'b0;
      end else if (64'(cpos_r) >= MAX_ROW_LENGTH) begin
        out_data.min_index    <= 16'(32'(bpos_r));
        out_data.row_overflow <= 1'b1;
      end else begin
        out_data.min_index    <= less ? 16'(32'(cpos_r)) : 16'(32'(bpos_r));
        out_data.row_overflow <= ovf_r;
      end
    end
  end

endmodule

// File: rtl/ram_cmp.sv
// Type-dependent strict less-than between a new element and the stored minimum.
module ram_cmp (
  input  logic [3:0]  elem_type,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        less
);

  always_comb begin
    case (elem_type)
      ram_pkg::ET_U8:   less = ram_pkg::int_less(a, b, 8, 1'b0);
      ram_pkg::ET_I8:   less = ram_pkg::int_less(a, b, 8, 1'b1);
      ram_pkg::ET_I16:  less = ram_pkg::int_less(a, b, 16, 1'b1);
      ram_pkg::ET_I32:  less = ram_pkg::int_less(a, b, 32, 1'b1);
      ram_pkg::ET_I64:  less = ram_pkg::int_less(a, b, 64, 1'b1);
      ram_pkg::ET_U16:  less = ram_pkg::int_less(a, b, 16, 1'b0);
      ram_pkg::ET_U32:  less = ram_pkg::int_less(a, b, 32, 1'b0);
      ram_pkg::ET_F32:  less = ram_pkg::float_less(a, b, 32, 23);
      ram_pkg::ET_F64:  less = ram_pkg::float_less(a, b, 64, 52);
      ram_pkg::ET_F16:  less = ram_pkg::float_less(a, b, 16, 10);
      ram_pkg::ET_BF16: less = ram_pkg::float_less(a, b, 16, 7);
      default:          less = ram_pkg::int_less(a, b, 64, 1'b0);
    endcase
  end

endmodule

// File: rtl/ram_checker.sv
// Port-level checks for the argmin block.
module ram_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ram_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ram_pkg::out_req_t out_data
);

  // A request on the output appears only after a last element was taken.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_in_row))
    else $error("result without a last element");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input is open whenever no result waits.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

endmodule

bind row_argmin_reduction ram_checker u_ram_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
